// ===== hdl/mspid_pkg.sv =====
// Shared types and constants of the motor speed controller.
// Used by mspid_core and motor_speed_pid_bang_bang; no dependencies.

package mspid_pkg;

   // fraction bits of the gains and of the drive accumulator
   localparam int GAIN_FRAC_BITS = 10;

   // scaled output limit and stored drive widths
   localparam int LIMQ_W  = 16 + GAIN_FRAC_BITS;
   localparam int DRIVE_W = LIMQ_W + 1;

   // register indexes on the csr port
   localparam logic [2:0] REG_MODE           = 3'd0;
   localparam logic [2:0] REG_GAIN_P         = 3'd1;
   localparam logic [2:0] REG_GAIN_I         = 3'd2;
   localparam logic [2:0] REG_GAIN_D         = 3'd3;
   localparam logic [2:0] REG_OUTPUT_LIMIT   = 3'd4;
   localparam logic [2:0] REG_BANG_THRESHOLD = 3'd5;
   localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd6;

   // register reset values
   localparam logic        MODE_RST           = 1'b0;
   localparam logic [15:0] GAIN_P_RST         = 16'd28672;
   localparam logic [15:0] GAIN_I_RST         = 16'd2872;
   localparam logic [15:0] GAIN_D_RST         = 16'd133;
   localparam logic [15:0] OUTPUT_LIMIT_RST   = 16'd10000;
   localparam logic [15:0] BANG_THRESHOLD_RST = 16'd100;
   localparam logic [30:0] INTEGRAL_LIMIT_RST = 31'd3565;

   // mode codes
   localparam logic MODE_INCREMENTAL = 1'b0;
   localparam logic MODE_POSITIONAL  = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [15:0] output_limit;
      logic [15:0] bang_threshold;
      logic [30:0] integral_limit;
      logic [15:0] duty_cap;    // floor(3*limit/5)
      logic [15:0] bang_duty;   // floor(2*limit/5)
   } cfg_type;

   typedef struct packed {
      logic signed [16:0]        err_now;
      logic signed [16:0]        err_prev;
      logic signed [16:0]        err_prev2;
      logic signed [31:0]        integral_sum;
      logic signed [DRIVE_W-1:0] drive_acc;
   } state_type;

   typedef struct packed {
      logic        forward;
      logic [15:0] duty;
      logic        bang_active;
   } result_type;

endpackage

// ===== hdl/motor_speed_pid_bang_bang.sv =====
// Top level of the motor speed controller with bang-bang override.
// Depends on mspid_pkg and mspid_core.
//
// Use: each word on the req_ channel is one control tick (target and measured
// speed). Each tick gives exactly one word on the rsp_ channel: direction,
// duty and a flag for bang-bang drive. Registers are written through the csr_
// channel (index, data), which is always ready; write them only while no tick
// is in flight.
// Path: an accepted tick is stored in the input register, computed from it by
// the core, and its word is registered in the result register when the tick
// leaves the input register.
// Throughput: one tick per cycle while rsp_ready is high. The controller state
// (error history, integral, drive) is read and written in the same cycle by the
// single-pass datapath, so each tick sees the state left by the one before.
// Stall: while rsp_ready is low a full result register holds; req_ready stays high
// as long as the input register is empty or can move on, so one more tick is
// taken and waits in the input register.
// Reset (synchronous): registers go to their defaults, the state to zero, and
// both stages are emptied. Duty limits derived from output_limit are registered
// from the stored output_limit, so they follow a write to it.

module motor_speed_pid_bang_bang (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_target_speed,
   input  logic signed [15:0] req_measured_speed,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_forward,
   output logic        [15:0] rsp_duty,
   output logic               rsp_bang_active,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [2:0]  csr_index,
   input  logic        [30:0] csr_data
);
   import mspid_pkg::*;

   // floor(x/5) for x below 2^18, by reciprocal multiply
   function automatic logic [15:0] div5(input logic [17:0] x);
      logic [36:0] prod;
      prod = 37'(x) * 37'd419431;
      return prod[36:21];
   endfunction

   logic        mode_ff;
   logic [15:0] gain_p_ff;
   logic [15:0] gain_i_ff;
   logic [15:0] gain_d_ff;
   logic [15:0] output_limit_ff;
   logic [15:0] bang_threshold_ff;
   logic [30:0] integral_limit_ff;
   logic [15:0] duty_cap_ff;
   logic [15:0] bang_duty_ff;
   logic [17:0] limit_x3;
   logic [17:0] limit_x2;

   logic               in_valid_ff;
   logic signed [15:0] in_target_ff;
   logic signed [15:0] in_measured_ff;
   logic               advance;

   state_type  state_ff;
   state_type  state_in;
   cfg_type    cfg;
   result_type result_in;
   result_type rsp_ff;
   logic       rsp_valid_ff;

   // config registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_RST;
         gain_p_ff         <= GAIN_P_RST;
         gain_i_ff         <= GAIN_I_RST;
         gain_d_ff         <= GAIN_D_RST;
         output_limit_ff   <= OUTPUT_LIMIT_RST;
         bang_threshold_ff <= BANG_THRESHOLD_RST;
         integral_limit_ff <= INTEGRAL_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MODE:           mode_ff           <= csr_data[0];
            REG_GAIN_P:         gain_p_ff         <= csr_data[15:0];
            REG_GAIN_I:         gain_i_ff         <= csr_data[15:0];
            REG_GAIN_D:         gain_d_ff         <= csr_data[15:0];
            REG_OUTPUT_LIMIT:   output_limit_ff   <= csr_data[15:0];
            REG_BANG_THRESHOLD: bang_threshold_ff <= csr_data[15:0];
            REG_INTEGRAL_LIMIT: integral_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign limit_x2 = {1'b0, output_limit_ff, 1'b0};
   assign limit_x3 = {2'b00, output_limit_ff} + limit_x2;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_cap_ff  <= div5(18'(OUTPUT_LIMIT_RST) * 18'd3);
         bang_duty_ff <= div5(18'(OUTPUT_LIMIT_RST) * 18'd2);
      end else begin
         duty_cap_ff  <= div5(limit_x3);
         bang_duty_ff <= div5(limit_x2);
      end
   end

   always_comb begin
      cfg.mode           = mode_ff;
      cfg.gain_p         = gain_p_ff;
      cfg.gain_i         = gain_i_ff;
      cfg.gain_d         = gain_d_ff;
      cfg.output_limit   = output_limit_ff;
      cfg.bang_threshold = bang_threshold_ff;
      cfg.integral_limit = integral_limit_ff;
      cfg.duty_cap       = duty_cap_ff;
      cfg.bang_duty      = bang_duty_ff;
   end

   // input register
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_target_ff   <= req_target_speed;
         in_measured_ff <= req_measured_speed;
      end
   end

   mspid_core u_core (
      .cfg            (cfg),
      .st             (state_ff),
      .target_speed   (in_target_ff),
      .measured_speed (in_measured_ff),
      .st_next        (state_in),
      .res            (result_in)
   );

   // controller state moves with each word that leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_forward     = rsp_ff.forward;
   assign rsp_duty        = rsp_ff.duty;
   assign rsp_bang_active = rsp_ff.bang_active;

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("word left input register but no result followed");

   a_pid_duty_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.bang_active |-> rsp_ff.duty <= duty_cap_ff)
      else $error("pid duty above 60 percent cap");

   a_bang_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.bang_active |-> rsp_ff.duty == bang_duty_ff)
      else $error("bang duty differs from 40 percent of limit");

   a_bang_clears_state: assert property (@(posedge clock) disable iff (reset)
      advance && result_in.bang_active |=>
         state_ff.integral_sum == '0 && state_ff.err_now == '0 &&
         state_ff.err_prev == '0 && state_ff.err_prev2 == '0)
      else $error("bang tick did not clear history and integral");

   a_bang_keeps_drive: assert property (@(posedge clock) disable iff (reset)
      advance && result_in.bang_active |=> $stable(state_ff.drive_acc))
      else $error("bang tick changed the drive accumulator");

endmodule

// ===== hdl/mspid_core.sv =====
// Single-pass datapath of the speed controller: error, bang-bang test,
// incremental or positional PID update, clamps and duty. Uses mspid_pkg.

module mspid_core (
   input  mspid_pkg::cfg_type    cfg,
   input  mspid_pkg::state_type  st,
   input  logic signed [15:0]    target_speed,
   input  logic signed [15:0]    measured_speed,
   output mspid_pkg::state_type  st_next,
   output mspid_pkg::result_type res
);
   import mspid_pkg::*;

   localparam int ACC_W = 50;

   function automatic logic signed [ACC_W-1:0] clamp_acc(
      input logic signed [ACC_W-1:0] v,
      input logic signed [ACC_W-1:0] lim
   );
      logic signed [ACC_W-1:0] r;
      r = v;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

   logic signed [16:0]        err;
   logic        [16:0]        err_mag;
   logic                      bang;
   logic signed [16:0]        e_pid;
   logic signed [16:0]        gp;
   logic signed [16:0]        gi;
   logic signed [16:0]        gd;
   logic signed [ACC_W-1:0]   lim_q;
   logic signed [ACC_W-1:0]   half_q;
   // incremental path
   logic signed [17:0]        inc_d1;
   logic signed [18:0]        inc_d2;
   logic signed [34:0]        inc_p;
   logic signed [33:0]        inc_i;
   logic signed [35:0]        inc_d;
   logic signed [ACC_W-1:0]   inc_delta;
   logic signed [ACC_W-1:0]   inc_sum;
   logic signed [ACC_W-1:0]   inc_drive;
   // positional path
   logic signed [32:0]        isum_raw;
   logic signed [32:0]        isum_lim;
   logic signed [31:0]        isum_new;
   logic signed [17:0]        pos_d1;
   logic signed [33:0]        pos_p;
   logic signed [48:0]        pos_i;
   logic signed [34:0]        pos_d;
   logic signed [ACC_W-1:0]   pos_sum;
   logic signed [ACC_W-1:0]   pos_drive;
   // output
   logic signed [DRIVE_W-1:0] drive_new;
   logic        [DRIVE_W-1:0] drive_mag;
   logic        [DRIVE_W-GAIN_FRAC_BITS-1:0] duty_full;

   assign err     = 17'(target_speed) - 17'(measured_speed);
   assign err_mag = err[16] ? 17'(-err) : 17'(err);
   assign bang    = err_mag > {1'b0, cfg.bang_threshold};
   // large positive error is replaced by a small one
   assign e_pid   = (err > 17'sd4000) ? 17'sd6 : err;

   assign gp = $signed({1'b0, cfg.gain_p});
   assign gi = $signed({1'b0, cfg.gain_i});
   assign gd = $signed({1'b0, cfg.gain_d});

   assign lim_q  = $signed({{(ACC_W-16-GAIN_FRAC_BITS){1'b0}}, cfg.output_limit,
                            {GAIN_FRAC_BITS{1'b0}}});
   assign half_q = lim_q >>> 1;

   // incremental: history shifts, e0 = e_pid, e1 = err_now, e2 = err_prev
   assign inc_d1 = 18'(e_pid) - 18'(st.err_now);
   assign inc_d2 = 19'(e_pid) - (19'(st.err_now) <<< 1) + 19'(st.err_prev);
   assign inc_p  = gp * inc_d1;
   assign inc_i  = gi * e_pid;
   assign inc_d  = gd * inc_d2;
   assign inc_delta = clamp_acc(ACC_W'(inc_p) + ACC_W'(inc_i) + ACC_W'(inc_d), half_q);
   assign inc_sum   = ACC_W'(st.drive_acc) + inc_delta;
   assign inc_drive = clamp_acc(inc_sum, lim_q);

   // positional
   assign isum_raw = 33'(st.integral_sum) + 33'(e_pid);
   assign isum_lim = $signed({2'b00, cfg.integral_limit});
   always_comb begin
      if (isum_raw > isum_lim) begin
         isum_new = isum_lim[31:0];
      end else if (isum_raw < -isum_lim) begin
         isum_new = 32'(-isum_lim);
      end else begin
         isum_new = isum_raw[31:0];
      end
   end
   assign pos_d1    = 18'(e_pid) - 18'(st.err_now);
   assign pos_p     = gp * e_pid;
   assign pos_i     = gi * isum_new;
   assign pos_d     = gd * pos_d1;
   assign pos_sum   = ACC_W'(pos_p) + ACC_W'(pos_i) + ACC_W'(pos_d);
   assign pos_drive = clamp_acc(pos_sum, lim_q);

   assign drive_new = (cfg.mode == MODE_POSITIONAL) ? DRIVE_W'(pos_drive) : DRIVE_W'(inc_drive);
   assign drive_mag = drive_new[DRIVE_W-1] ? DRIVE_W'(-drive_new) : DRIVE_W'(drive_new);
   assign duty_full = drive_mag[DRIVE_W-1:GAIN_FRAC_BITS];

   always_comb begin
      st_next = st;
      res     = '0;
      if (bang) begin
         st_next.err_now      = '0;
         st_next.err_prev     = '0;
         st_next.err_prev2    = '0;
         st_next.integral_sum = '0;
         res.forward          = !err[16] && (err != '0);
         res.duty             = cfg.bang_duty;
         res.bang_active      = 1'b1;
      end else begin
         if (cfg.mode == MODE_POSITIONAL) begin
            st_next.integral_sum = isum_new;
            st_next.err_now      = e_pid;
         end else begin
            st_next.err_prev2 = st.err_prev;
            st_next.err_prev  = st.err_now;
            st_next.err_now   = e_pid;
         end
         st_next.drive_acc = drive_new;
         res.forward       = !drive_new[DRIVE_W-1];
         if (duty_full > (DRIVE_W-GAIN_FRAC_BITS)'(cfg.duty_cap)) begin
            res.duty = cfg.duty_cap;
         end else begin
            res.duty = 16'(duty_full);
         end
         res.bang_active = 1'b0;
      end
   end

endmodule
